[rtl/lpm_pkg.sv]
// package: shared types, codes and helpers for the route table unit
`default_nettype none
package lpm_pkg;
   localparam int ROUTE_SLOTS_DEFAULT = 32;
   localparam int MAX_HOPS_DEFAULT = 8;
   localparam logic [7:0] HOST_LEN = 8'd128;

   localparam logic [2:0] CMD_ADD_HOST      = 3'd0;
   localparam logic [2:0] CMD_ADD_PREFIX    = 3'd1;
   localparam logic [2:0] CMD_REMOVE_HOST   = 3'd2;
   localparam logic [2:0] CMD_REMOVE_PREFIX = 3'd3;
   localparam logic [2:0] CMD_EXPIRE_HOST   = 3'd4;
   localparam logic [2:0] CMD_EXPIRE_PREFIX = 3'd5;
   localparam logic [2:0] CMD_LOOKUP        = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [7:0]  prefix_bits;
      logic [7:0]  hop_count;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
      logic [4:0] slot_index;
      logic [7:0] matched_bits;
      logic [5:0] prefix_routes;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } dp_stat_type;

   function automatic logic [127:0] len_mask(input logic [7:0] len);
      logic [127:0] m;
      m = '0;
      if (len >= 8'd128) m = '1;
      else if (len != 8'd0) m = ~({128{1'b1}} >> len);
      return m;
   endfunction
endpackage
`default_nettype wire

[rtl/lpm_datapath.sv]
// datapath: route store, slot scan and result formation
`default_nettype none
module lpm_datapath #(
   parameter int ROUTE_SLOTS = lpm_pkg::ROUTE_SLOTS_DEFAULT,
   parameter int MAX_HOPS = lpm_pkg::MAX_HOPS_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  lpm_pkg::dp_cmd_type  cmd,
   input  lpm_pkg::req_word_type req,
   output lpm_pkg::dp_stat_type stat,
   output lpm_pkg::rsp_word_type rsp
);
   import lpm_pkg::*;
   localparam int IW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

   logic [ROUTE_SLOTS-1:0] valid_ff;
   logic [ROUTE_SLOTS-1:0] pref_bit_ff;
   logic [7:0]   len_mem [ROUTE_SLOTS];
   logic [127:0] tgt_mem [ROUTE_SLOTS];

   req_word_type  req_ff;
   logic [127:0]  canon_ff;
   logic [IW-1:0] idx_ff;
   logic [7:0]    rd_len_ff;
   logic [127:0]  rd_tgt_ff;
   logic          rd_valid_ff, rd_pref_ff, rd_live_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          match_ff, free_ff, best_ok_ff;
   logic [IW-1:0] match_ix_ff, free_ix_ff, best_ix_ff;
   logic [7:0]    top_len_ff;
   logic [5:0]    total_ff;
   rsp_word_type  rsp_ff;

   wire logic [127:0] addr = {req_ff.addr_high, req_ff.addr_low};
   wire logic is_pcmd = req_ff.command == CMD_ADD_PREFIX ||
      req_ff.command == CMD_REMOVE_PREFIX || req_ff.command == CMD_EXPIRE_PREFIX;
   wire logic hops_ok = req_ff.hop_count >= 8'd1 &&
      {24'd0, req_ff.hop_count} <= 32'(MAX_HOPS);
   wire logic len_ok = req_ff.prefix_bits >= 8'd1 && req_ff.prefix_bits <= 8'd127;

   // compare of the registered entry
   logic exact_hit, lpm_hit;
   always_comb begin
      if (is_pcmd)
         exact_hit = rd_live_ff && rd_valid_ff && rd_pref_ff &&
            rd_len_ff == req_ff.prefix_bits && rd_tgt_ff == canon_ff;
      else
         exact_hit = rd_live_ff && rd_valid_ff && !rd_pref_ff &&
            rd_len_ff == HOST_LEN && rd_tgt_ff == addr;
      if (rd_pref_ff)
         lpm_hit = total_ff != 6'd0 && rd_len_ff != 8'd0 &&
            (addr & len_mask(rd_len_ff)) == rd_tgt_ff;
      else
         lpm_hit = rd_tgt_ff == addr;
      lpm_hit = lpm_hit && rd_live_ff && rd_valid_ff;
   end
   wire logic [7:0] m_len = rd_pref_ff ? rd_len_ff : HOST_LEN;

   assign stat.scan_last = idx_ff == IW'(ROUTE_SLOTS - 1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         canon_ff <= {req.addr_high, req.addr_low} & len_mask(req.prefix_bits);
         idx_ff <= '0;
         rd_live_ff <= 1'b0;
         match_ff <= 1'b0; free_ff <= 1'b0; best_ok_ff <= 1'b0;
         top_len_ff <= '0;
         match_ix_ff <= '0; free_ix_ff <= '0; best_ix_ff <= '0;
      end else begin
         if (cmd.scan) begin
            rd_len_ff <= len_mem[idx_ff];
            rd_tgt_ff <= tgt_mem[idx_ff];
            rd_valid_ff <= valid_ff[idx_ff];
            rd_pref_ff <= pref_bit_ff[idx_ff];
            rd_idx_ff <= idx_ff;
            rd_live_ff <= 1'b1;
            if (!stat.scan_last) idx_ff <= idx_ff + IW'(1);
            if (!valid_ff[idx_ff] && !free_ff) begin
               free_ff <= 1'b1; free_ix_ff <= idx_ff;
            end
         end else begin
            rd_live_ff <= 1'b0;
         end
         if (exact_hit && !match_ff) begin
            match_ff <= 1'b1; match_ix_ff <= rd_idx_ff;
         end
         if (lpm_hit && m_len > top_len_ff) begin
            best_ok_ff <= 1'b1; best_ix_ff <= rd_idx_ff; top_len_ff <= m_len;
         end
      end
   end

   // commit
   logic         wr_en, clr_en, inc, dec;
   logic [IW-1:0] wr_ix;
   rsp_word_type r;
   always_comb begin
      r = '0;
      wr_en = 1'b0; clr_en = 1'b0; inc = 1'b0; dec = 1'b0;
      wr_ix = match_ff ? match_ix_ff : free_ix_ff;
      case (req_ff.command)
         CMD_ADD_HOST, CMD_ADD_PREFIX: begin
            if (!hops_ok || (req_ff.command == CMD_ADD_PREFIX && !len_ok))
               r.status = ST_INVALID;
            else if (!match_ff && !free_ff) r.status = ST_FULL;
            else begin
               wr_en = 1'b1;
               inc = req_ff.command == CMD_ADD_PREFIX && !match_ff;
               r.slot_index = 5'(wr_ix);
            end
         end
         CMD_REMOVE_HOST, CMD_EXPIRE_HOST: begin
            if (!match_ff) r.status = ST_NOT_FOUND;
            else begin
               clr_en = 1'b1; r.slot_index = 5'(match_ix_ff);
            end
         end
         CMD_REMOVE_PREFIX, CMD_EXPIRE_PREFIX: begin
            if (!len_ok) r.status = ST_INVALID;
            else if (!match_ff) r.status = ST_NOT_FOUND;
            else begin
               clr_en = 1'b1; dec = 1'b1; wr_ix = match_ix_ff;
               r.slot_index = 5'(match_ix_ff);
            end
         end
         CMD_LOOKUP: begin
            if (!best_ok_ff) r.status = ST_NOT_FOUND;
            else begin
               r.hit = 1'b1; r.slot_index = 5'(best_ix_ff);
               r.matched_bits = top_len_ff;
            end
         end
         default: r.status = ST_INVALID;
      endcase
      if (clr_en) wr_ix = match_ix_ff;
   end

   logic [5:0] total_in;
   always_comb begin
      total_in = total_ff;
      if (inc && total_ff != 6'd63) total_in = total_ff + 6'd1;
      if (dec && total_ff != 6'd0) total_in = total_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pref_bit_ff <= '0;
         total_ff <= '0;
      end else if (cmd.finish) begin
         total_ff <= total_in;
         if (wr_en) begin
            valid_ff[wr_ix] <= 1'b1;
            pref_bit_ff[wr_ix] <= is_pcmd;
         end
         if (clr_en) valid_ff[wr_ix] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && wr_en) begin
         len_mem[wr_ix] <= is_pcmd ? req_ff.prefix_bits : HOST_LEN;
         tgt_mem[wr_ix] <= is_pcmd ? canon_ff : addr;
      end
      if (cmd.finish) begin
         rsp_ff <= {r.status, r.hit, r.slot_index, r.matched_bits, total_in};
      end
   end
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

[rtl/lpm_control.sv]
// controller: sequences load, slot scan and commit
`default_nettype none
module lpm_control (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  lpm_pkg::dp_stat_type stat,
   output lpm_pkg::dp_cmd_type  cmd,
   output logic                 busy,
   output logic                 done
);
   import lpm_pkg::*;
   typedef enum logic [2:0] {IDLE, SCAN, DRAIN, TAIL, FINISH, REPLY} state_type;
   state_type state_ff;

   always_comb begin
      cmd.load = start && state_ff == IDLE;
      cmd.scan = state_ff == SCAN;
      cmd.finish = state_ff == FINISH;
      busy = state_ff != IDLE;
      done = state_ff == REPLY;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else begin
         case (state_ff)
            IDLE:   if (start) state_ff <= SCAN;
            SCAN:   if (stat.scan_last) state_ff <= DRAIN;
            DRAIN:  state_ff <= TAIL;
            TAIL:   state_ff <= FINISH;
            FINISH: state_ff <= REPLY;
            REPLY:  state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[rtl/lpm_route_table_unit.sv]
// top level: longest prefix match route table
// rsp_valid rises after the SCAN, DRAIN, TAIL and FINISH states that follow the accepting edge
// a new command is taken only in IDLE, so the slot scan of each command must end before the next starts
// reset clears all valid bits and the prefix route count
// each result word is shown for one cycle on rsp_valid; the receiver cannot stall
`default_nettype none
module lpm_route_table_unit #(
   parameter int ROUTE_SLOTS = lpm_pkg::ROUTE_SLOTS_DEFAULT,
   parameter int MAX_HOPS = lpm_pkg::MAX_HOPS_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  lpm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output lpm_pkg::rsp_word_type rsp_word
);
   import lpm_pkg::*;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   lpm_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .cmd(cmd), .busy(busy), .done(rsp_valid)
   );
   lpm_datapath #(.ROUTE_SLOTS(ROUTE_SLOTS), .MAX_HOPS(MAX_HOPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_word),
      .stat(stat), .rsp(rsp_word)
   );
endmodule
`default_nettype wire

[tb/sv/lpm_route_table_unit_test.sv]
// testbench for the longest prefix match route table unit
`default_nettype none
module lpm_route_table_unit_test;
   import lpm_pkg::*;

   localparam int SLOTS = 32;
   localparam int HOPS_MAX = 8;
   localparam int LATENCY = SLOTS + 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_WORDS = 459;
   localparam logic [2:0] CMD_UNKNOWN = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic rsp_valid;
   rsp_word_type rsp_word;

   lpm_route_table_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always #4 clock = ~clock;

   logic         route_valid [SLOTS];
   logic         route_pref [SLOTS];
   logic [7:0]   route_length [SLOTS];
   logic [127:0] route_target [SLOTS];
   int unsigned  prefix_total;

   rsp_word_type expected_rsp [$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;

   // pool of addresses so adds, removes and lookups collide
   logic [127:0] addr_pool [16];

   function automatic logic [127:0] prefix_mask(input logic [7:0] len);
      logic [127:0] m;
      m = '0;
      for (int b = 0; b < 128; b++)
         if (b < len) m[127 - b] = 1'b1;
      return m;
   endfunction

   function automatic int match_slot(input logic want_pref, input logic [7:0] len,
                                     input logic [127:0] target);
      for (int i = 0; i < SLOTS; i++)
         if (route_valid[i] && route_pref[i] == want_pref && route_length[i] == len &&
             route_target[i] == target)
            return i;
      return -1;
   endfunction

   function automatic int find_free_slot();
      for (int i = 0; i < SLOTS; i++)
         if (!route_valid[i]) return i;
      return -1;
   endfunction

   function automatic rsp_word_type route_table_update(input req_word_type w);
      rsp_word_type r;
      logic [127:0] addr, canon;
      int s, best, top_len, m;
      bit hops_ok, len_ok, fresh;
      r = '0;
      addr = {w.addr_high, w.addr_low};
      canon = addr & prefix_mask(w.prefix_bits);
      hops_ok = w.hop_count >= 1 && w.hop_count <= HOPS_MAX;
      len_ok = w.prefix_bits >= 1 && w.prefix_bits <= 127;
      case (w.command)
         CMD_ADD_HOST: begin
            if (!hops_ok) r.status = ST_INVALID;
            else begin
               s = match_slot(1'b0, HOST_LEN, addr);
               if (s < 0) s = find_free_slot();
               if (s < 0) r.status = ST_FULL;
               else begin
                  route_valid[s] = 1'b1; route_pref[s] = 1'b0;
                  route_length[s] = HOST_LEN; route_target[s] = addr;
                  r.slot_index = s[4:0];
               end
            end
         end
         CMD_ADD_PREFIX: begin
            if (!len_ok || !hops_ok) r.status = ST_INVALID;
            else begin
               s = match_slot(1'b1, w.prefix_bits, canon);
               fresh = s < 0;
               if (fresh) s = find_free_slot();
               if (s < 0) r.status = ST_FULL;
               else begin
                  route_valid[s] = 1'b1; route_pref[s] = 1'b1;
                  route_length[s] = w.prefix_bits; route_target[s] = canon;
                  if (fresh && prefix_total < 63) prefix_total++;
                  r.slot_index = s[4:0];
               end
            end
         end
         CMD_REMOVE_HOST, CMD_EXPIRE_HOST: begin
            s = match_slot(1'b0, HOST_LEN, addr);
            if (s < 0) r.status = ST_NOT_FOUND;
            else begin
               route_valid[s] = 1'b0;
               r.slot_index = s[4:0];
            end
         end
         CMD_REMOVE_PREFIX, CMD_EXPIRE_PREFIX: begin
            if (!len_ok) r.status = ST_INVALID;
            else begin
               s = match_slot(1'b1, w.prefix_bits, canon);
               if (s < 0) r.status = ST_NOT_FOUND;
               else begin
                  route_valid[s] = 1'b0;
                  if (prefix_total > 0) prefix_total--;
                  r.slot_index = s[4:0];
               end
            end
         end
         CMD_LOOKUP: begin
            best = -1;
            top_len = 0;
            for (int i = 0; i < SLOTS; i++) begin
               m = 0;
               if (!route_valid[i]) continue;
               if (route_pref[i]) begin
                  if (prefix_total == 0) continue;
                  if ((addr & prefix_mask(route_length[i])) == route_target[i])
                     m = int'(route_length[i]);
               end else if (route_target[i] == addr) m = int'(HOST_LEN);
               if (m > top_len) begin
                  best = i;
                  top_len = m;
               end
            end
            if (best < 0) r.status = ST_NOT_FOUND;
            else begin
               r.hit = 1'b1;
               r.slot_index = best[4:0];
               r.matched_bits = top_len[7:0];
            end
         end
         default: r.status = ST_INVALID;
      endcase
      r.prefix_routes = prefix_total[5:0];
      return r;
   endfunction

   // send one word; a nonzero use_typed takes the typed expectation instead of the predictor
   task automatic send_word(input req_word_type w, input rsp_word_type typed, input int use_typed);
      rsp_word_type p;
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(negedge clock);
      while (busy) @(negedge clock);
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      p = route_table_update(w);
      expected_rsp.push_back(use_typed != 0 ? typed : p);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   function automatic req_word_type make_word(input logic [2:0] c, input logic [127:0] a,
                                              input int len, input int hops);
      req_word_type w;
      w.command = c;
      {w.addr_high, w.addr_low} = a;
      w.prefix_bits = 8'(len);
      w.hop_count = 8'(hops);
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(input logic [1:0] st, input int h,
                                             input int s, input int b,
                                             input int n);
      rsp_word_type r;
      r.status = st; r.hit = 1'(h); r.slot_index = 5'(s); r.matched_bits = 8'(b);
      r.prefix_routes = 6'(n);
      return r;
   endfunction

   function automatic req_word_type random_word();
      logic [127:0] a;
      logic [2:0] c;
      logic [7:0] len, hops;
      int pick;
      a = addr_pool[$urandom_range(15, 0)];
      pick = $urandom_range(99, 0);
      if (pick < 10) a = {$urandom(), $urandom(), $urandom(), $urandom()};
      else if (pick < 40) a[63:0] = {$urandom(), $urandom()};
      c = $urandom_range(99, 0) < 3 ? CMD_UNKNOWN : 3'($urandom_range(6, 0));
      len = $urandom_range(99, 0) < 8 ? 8'($urandom()) : 8'($urandom_range(127, 1));
      if ($urandom_range(3, 0) == 0) len = 8'($urandom_range(16, 1) * 8);
      hops = $urandom_range(99, 0) < 6 ? 8'($urandom()) : 8'($urandom_range(HOPS_MAX, 1));
      return make_word(c, a, int'(len), int'(hops));
   endfunction

   typedef struct {
      req_word_type w;
      int           typed;
      rsp_word_type r;
   } stim_row_type;

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected word %p", $time, rsp_word);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_word.status !== e.status || rsp_word.hit !== e.hit ||
                   rsp_word.slot_index !== e.slot_index ||
                   rsp_word.matched_bits !== e.matched_bits ||
                   rsp_word.prefix_routes !== e.prefix_routes) begin
                  $display("%0t mismatch expected %p actual %p", $time, e, rsp_word);
                  errors++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("lpm_route_table_unit test failed");
            $finish;
         end
      end
   end

   localparam logic [127:0] ONES = '1;
   localparam logic [127:0] HOST_A = 128'h2001_0db8_0000_0000_0000_0000_0000_0001;

   initial begin
      stim_row_type rows [$];
      for (int i = 0; i < SLOTS; i++) begin
         route_valid[i] = 1'b0; route_pref[i] = 1'b0; route_length[i] = '0;
         route_target[i] = '0;
      end
      prefix_total = 0;
      for (int i = 0; i < 16; i++)
         addr_pool[i] = {16'h2001, 12'h0db, 4'(i % 4), 32'($urandom_range(3, 0)),
                         16'($urandom_range(1, 0)), 48'($urandom())};
      addr_pool[0] = '0;
      addr_pool[1] = ONES;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows = '{
         '{make_word(CMD_LOOKUP, HOST_A, 0, 1), 1, make_rsp(ST_NOT_FOUND, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_HOST, HOST_A, 0, 0), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_HOST, HOST_A, 0, 9), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_HOST, HOST_A, 0, 255), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_PREFIX, HOST_A, 0, 1), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_PREFIX, HOST_A, 128, 1), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_PREFIX, HOST_A, 255, 1), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_UNKNOWN, ONES, 255, 255), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_REMOVE_PREFIX, HOST_A, 0, 1), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_EXPIRE_PREFIX, HOST_A, 128, 1), 1, make_rsp(ST_INVALID, 0, 0, 0, 0)},
         '{make_word(CMD_REMOVE_HOST, HOST_A, 0, 1), 1, make_rsp(ST_NOT_FOUND, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_HOST, HOST_A, 0, 1), 1, make_rsp(ST_OK, 0, 0, 0, 0)},
         '{make_word(CMD_ADD_HOST, ONES, 0, 8), 1, make_rsp(ST_OK, 0, 1, 0, 0)},
         '{make_word(CMD_LOOKUP, HOST_A, 0, 0), 1, make_rsp(ST_OK, 1, 0, 128, 0)},
         '{make_word(CMD_ADD_PREFIX, ONES, 1, 1), 0, '0},
         '{make_word(CMD_ADD_PREFIX, ONES, 127, 8), 0, '0},
         '{make_word(CMD_ADD_PREFIX, HOST_A, 32, 3), 0, '0},
         '{make_word(CMD_ADD_PREFIX, HOST_A | 128'hff, 32, 3), 0, '0},
         '{make_word(CMD_LOOKUP, HOST_A ^ 128'h1, 0, 0), 0, '0},
         '{make_word(CMD_LOOKUP, ONES ^ 128'h1, 0, 0), 0, '0},
         '{make_word(CMD_EXPIRE_HOST, HOST_A, 0, 0), 0, '0},
         '{make_word(CMD_REMOVE_PREFIX, ONES, 127, 0), 0, '0},
         '{make_word(CMD_EXPIRE_PREFIX, ONES, 1, 0), 0, '0},
         '{make_word(CMD_LOOKUP, 128'h0, 0, 0), 0, '0}
      };
      foreach (rows[i]) send_word(rows[i].w, rows[i].r, rows[i].typed);

      // fill the table to hit the full case, then remove the hosts that this loop added
      for (int i = 0; i < SLOTS + 2; i++)
         send_word(make_word(CMD_ADD_HOST, 128'(i) << 64, 0, 1), '0, 0);
      send_word(make_word(CMD_ADD_PREFIX, ONES, 64, 1), '0, 0);
      for (int i = 0; i < SLOTS + 2; i++)
         send_word(make_word(CMD_REMOVE_HOST, 128'(i) << 64, 0, 1), '0, 0);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 11 : (phase == 1 ? 79 : 0);
         for (int i = 0; i < RANDOM_WORDS / 3; i++) begin
            send_word(random_word(), '0, 0);
            if (i == 60) begin
               while (expected_rsp.size() != 0) @(negedge clock);
            end
         end
      end

      drain();
      if (errors == 0) $display("lpm_route_table_unit test passed");
      else $display("lpm_route_table_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire
